FILE: hw/rtl/dmm_pkg.sv
// Shared types and codes for the dense matrix multiply block.
// No dependencies; imported by dmm_mac, dense_matrix_multiply_top and the testbench.
`default_nettype none

package dmm_pkg;

    // Largest supported matrix dimension
    localparam int MAX_DIM_DEF = 8;

    // Dimension register value after reset
    localparam logic [3:0] DIM_RESET = 4'd8;

    // Request kinds on the input stream
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_LOAD_C = 2'd2;
    localparam logic [1:0] REQ_RUN    = 2'd3;

    // Product modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_TRANS = 2'd1;
    localparam logic [1:0] MODE_ACC   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_DIM_M = 2'd1;
    localparam logic [1:0] CFG_DIM_N = 2'd2;
    localparam logic [1:0] CFG_DIM_P = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FIN,
        ST_OUT
    } state_t;

    // Controls from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic prod_en;
        logic acc_en;
    } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dmm_mac.sv
// Shared multiply-accumulate unit with rounding, preload add and saturation.
// Depends on dmm_pkg for the control struct.
`default_nettype none

module dmm_mac
    import dmm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  wire logic               clk,
    input  wire mac_ctrl_t          ctrl,
    input  wire logic signed [31:0] a_val,
    input  wire logic signed [31:0] b_val,
    input  wire logic signed [31:0] c_val,
    input  wire logic               add_c,
    output logic signed [31:0]      result
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ACC_W = 64 + IDX_W;
    localparam int SUM_W = ACC_W - 15;

    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] total;

    // Register the product, then accumulate it exactly
    always_ff @(posedge clk)
    begin
        if (ctrl.prod_en)
        begin
            prod_reg <= a_val * b_val;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Drop 16 fraction bits with floor rounding, add the preload, saturate
    always_comb
    begin
        total = SUM_W'(signed'(acc_reg[ACC_W-1:16]))
              + SUM_W'(add_c ? c_val : 32'sd0);
        if ((&total[SUM_W-1:31]) || !(|total[SUM_W-1:31]))
        begin
            result = total[31:0];
        end
        else if (total[SUM_W-1])
        begin
            result = 32'sh8000_0000;
        end
        else
        begin
            result = 32'sh7FFF_FFFF;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dense_matrix_multiply_top.sv
// Dense matrix multiply top level: element stores, sequencer and output register.
// Depends on dmm_pkg and dmm_mac.
//
// Usage:
//   The slave stream (s_tvalid/s_tready) carries requests: s_tuser holds the
//   kind (load A, load B, load C, run); s_tdata holds row, column and value.
//   A load writes one element if it lies inside the matrix shape set by the
//   current mode and dimensions; otherwise it is dropped. A run emits every
//   result element in row-major order on the master stream, with m_tlast on
//   the final one. For each result element the sequencer issues the inner
//   store reads through the one shared 32x32 multiplier and accumulator,
//   lets the read and product registers drain, rounds and saturates into the
//   output register and then offers the element; the next element starts
//   only after that transfer.
//   The block accepts no request while a run is in progress; it is ready
//   again the cycle after the last result transfer.
//   If the receiver stalls, the result holds in the output register and the
//   sequencer waits. The configuration channel is always ready and should be
//   written only while the block is idle.
//   Reset returns the sequencer to idle, mode to plain product and all
//   dimensions to 8; the stores keep no reset value.
`default_nettype none

module dense_matrix_multiply_top
    import dmm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_data,
    // Request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // row_index[2:0], col_index[5:3], elem_value[37:6], zero
    input  wire logic [1:0]  s_tuser,  // req_type[1:0]
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6], zero
    output logic             m_tlast
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Clamp a dimension register to 1..MAX_DIM
    function automatic logic [CNT_W-1:0] eff_dim(input logic [3:0] d);
        logic [CNT_W-1:0] r;
        if (d == 4'd0)
        begin
            r = CNT_W'(1);
        end
        else if (32'(d) > MAX_DIM)
        begin
            r = CNT_W'(MAX_DIM);
        end
        else
        begin
            r = CNT_W'(d);
        end
        return r;
    endfunction

    // Store address of an element
    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        return ADDR_W'(32'(r) * MAX_DIM + 32'(c));
    endfunction

    // Configuration registers
    logic [1:0] mode_reg;
    logic [3:0] dim_m_reg;
    logic [3:0] dim_n_reg;
    logic [3:0] dim_p_reg;

    // Sequencer registers
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             rd_vld_reg;
    logic             prod_vld_reg;

    // Output registers
    logic [IDX_W-1:0]   out_row_reg;
    logic [IDX_W-1:0]   out_col_reg;
    logic signed [31:0] out_value_reg;
    logic               out_last_reg;

    // Stores and their read registers
    logic signed [31:0] a_mem [DEPTH];
    logic signed [31:0] b_mem [DEPTH];
    logic signed [31:0] c_mem [DEPTH];
    logic signed [31:0] a_rd_reg;
    logic signed [31:0] b_rd_reg;
    logic signed [31:0] c_rd_reg;

    // Request fields
    logic [1:0]         req_type;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] elem_value;

    logic [1:0]         md;
    logic [CNT_W-1:0]   m_eff, n_eff, p_eff;
    logic [CNT_W-1:0]   res_rows, inner;
    logic               in_xfer, out_xfer;
    logic               issue;
    logic               elem_last;
    logic               load_row_ok_a, load_row_ok_b, load_row_ok_c;
    logic [ADDR_W-1:0]  load_addr;
    logic [ADDR_W-1:0]  a_raddr, b_raddr, c_raddr;
    logic [IDX_W-1:0]   k_idx;
    mac_ctrl_t          mac_ctrl;
    logic signed [31:0] mac_result;

    assign req_type   = s_tuser;
    assign row_index  = s_tdata[2:0];
    assign col_index  = s_tdata[5:3];
    assign elem_value = s_tdata[37:6];

    // Effective mode and shapes
    assign md       = (mode_reg == MODE_TRANS || mode_reg == MODE_ACC) ? mode_reg : MODE_PLAIN;
    assign m_eff    = eff_dim(dim_m_reg);
    assign n_eff    = eff_dim(dim_n_reg);
    assign p_eff    = eff_dim(dim_p_reg);
    assign res_rows = (md == MODE_PLAIN) ? m_eff : n_eff;
    assign inner    = (md == MODE_PLAIN) ? n_eff : m_eff;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid && m_tready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            dim_m_reg <= DIM_RESET;
            dim_n_reg <= DIM_RESET;
            dim_p_reg <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[1:0];
                CFG_DIM_M: dim_m_reg <= cfg_data;
                CFG_DIM_N: dim_n_reg <= cfg_data;
                CFG_DIM_P: dim_p_reg <= cfg_data;
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    // Load range checks against the shape of the current mode
    assign load_row_ok_a = ({1'b0, row_index} < 4'(m_eff))    && ({1'b0, col_index} < 4'(n_eff));
    assign load_row_ok_b = ({1'b0, row_index} < 4'(inner))    && ({1'b0, col_index} < 4'(p_eff));
    assign load_row_ok_c = ({1'b0, row_index} < 4'(res_rows)) && ({1'b0, col_index} < 4'(p_eff));
    assign load_addr     = elem_addr(IDX_W'(row_index), IDX_W'(col_index));

    // Read addresses for the current element and inner step
    assign k_idx   = k_reg[IDX_W-1:0];
    assign a_raddr = (md == MODE_PLAIN) ? elem_addr(i_reg, k_idx) : elem_addr(k_idx, i_reg);
    assign b_raddr = elem_addr(k_idx, j_reg);
    assign c_raddr = elem_addr(i_reg, j_reg);

    // Stores: one write port for loads, one registered read port each
    always_ff @(posedge clk)
    begin
        if (in_xfer && req_type == REQ_LOAD_A && load_row_ok_a)
        begin
            a_mem[load_addr] <= elem_value;
        end
        if (in_xfer && req_type == REQ_LOAD_B && load_row_ok_b)
        begin
            b_mem[load_addr] <= elem_value;
        end
        if (in_xfer && req_type == REQ_LOAD_C && load_row_ok_c)
        begin
            c_mem[load_addr] <= elem_value;
        end
        a_rd_reg <= a_mem[a_raddr];
        b_rd_reg <= b_mem[b_raddr];
        c_rd_reg <= c_mem[c_raddr];
    end

    assign issue     = (state_reg == ST_MAC) && (k_reg < inner);
    assign elem_last = (CNT_W'(i_reg) + CNT_W'(1) == res_rows)
                    && (CNT_W'(j_reg) + CNT_W'(1) == p_eff);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        mac_ctrl   = '0;
        mac_ctrl.prod_en = rd_vld_reg;
        mac_ctrl.acc_en  = prod_vld_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && req_type == REQ_RUN)
                begin
                    i_next         = '0;
                    j_next         = '0;
                    k_next         = '0;
                    mac_ctrl.clear = 1'b1;
                    state_next     = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (issue)
                begin
                    k_next = k_reg + CNT_W'(1);
                end
                else if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_xfer)
                begin
                    if (out_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (CNT_W'(j_reg) + CNT_W'(1) == p_eff)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                        k_next         = '0;
                        mac_ctrl.clear = 1'b1;
                        state_next     = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers and read pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    // Capture the finished element into the output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN)
        begin
            out_row_reg   <= i_reg;
            out_col_reg   <= j_reg;
            out_value_reg <= mac_result;
            out_last_reg  <= elem_last;
        end
    end

    dmm_mac #(
        .MAX_DIM (MAX_DIM)
    ) u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .a_val  (a_rd_reg),
        .b_val  (b_rd_reg),
        .c_val  (c_rd_reg),
        .add_c  (md == MODE_ACC),
        .result (mac_result)
    );

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {2'b00, out_value_reg, 3'(out_col_reg), 3'(out_row_reg)};
    assign m_tlast  = out_last_reg;

    // Requests are never taken while a result is on offer
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !m_tvalid)
        else $error("request accepted while a result is pending");

    // The block returns to idle right after the final result transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not idle after the final result");

    // A run request makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == REQ_RUN) |=> !s_tready)
        else $error("run request did not start the sequencer");

    // Store reads are only in flight while accumulating
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg || prod_vld_reg) |-> (state_reg == ST_MAC))
        else $error("accumulate pipeline active outside the accumulate state");

endmodule

`default_nettype wire

FILE: tb/tb_dense_matrix_multiply_top.sv
// Self-checking testbench for dense_matrix_multiply_top: directed and random element
// loads and runs, with every result element checked against a product model kept here.
// Depends on dmm_pkg and the RTL of dense_matrix_multiply_top.
module tb_dense_matrix_multiply_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dmm_pkg::*;

    localparam int STORE_DEPTH     = MAX_DIM_DEF * MAX_DIM_DEF;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int IDLE_LIMIT      = 3000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int RANDOM_ITEMS    = 10;

    // Mode code with no meaning of its own; the block treats it as a plain product
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    localparam logic signed [71:0] SAT_MAX = 72'sd2147483647;
    localparam logic signed [71:0] SAT_MIN = -72'sd2147483648;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        last;
    } element_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // row_index[2:0], col_index[5:3], elem_value[37:6], zero
    logic [1:0]  s_tuser = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // out_row[2:0], out_col[5:3], out_value[37:6], zero
    logic        m_tlast;

    // Element stores and registers as the block should hold them
    logic signed [31:0] a_words [STORE_DEPTH];
    logic signed [31:0] b_words [STORE_DEPTH];
    logic signed [31:0] c_words [STORE_DEPTH];
    bit                 a_loaded [STORE_DEPTH];
    bit                 b_loaded [STORE_DEPTH];
    bit                 c_loaded [STORE_DEPTH];
    logic [1:0]         mode_reg = MODE_PLAIN;
    logic [3:0]         dim_m_reg = DIM_RESET;
    logic [3:0]         dim_n_reg = DIM_RESET;
    logic [3:0]         dim_p_reg = DIM_RESET;

    element_t pending_elements [$];
    element_t expected_elem;
    int       error_count = 0;
    int       effective_items = 0;
    int       burst_left = 0;
    int       hold_off_requests = 0;
    int       hold_off_seen = 0;
    int       hold_off_left = 0;
    int       stall_phase = 0;
    logic [15:0] stall_pattern = '1;
    int       idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dense_matrix_multiply_top #(
        .MAX_DIM (MAX_DIM_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // A dimension of zero counts as one, anything above the maximum as the maximum
    function automatic int unsigned clamp_dim(input logic [3:0] d);
        if (d == 4'd0)
            return 1;
        if (d > MAX_DIM_DEF)
            return MAX_DIM_DEF;
        return d;
    endfunction

    function automatic logic [1:0] active_mode();
        return (mode_reg > MODE_ACC) ? MODE_PLAIN : mode_reg;
    endfunction

    // Rows of the matrix a load kind addresses; the result shares the shape of C
    function automatic int unsigned shape_rows(input logic [1:0] kind);
        bit plain;
        plain = (active_mode() == MODE_PLAIN);
        case (kind)
            REQ_LOAD_A: return clamp_dim(dim_m_reg);
            REQ_LOAD_B: return plain ? clamp_dim(dim_n_reg) : clamp_dim(dim_m_reg);
            default:    return plain ? clamp_dim(dim_m_reg) : clamp_dim(dim_n_reg);
        endcase
    endfunction

    function automatic int unsigned shape_cols(input logic [1:0] kind);
        return (kind == REQ_LOAD_A) ? clamp_dim(dim_n_reg) : clamp_dim(dim_p_reg);
    endfunction

    function automatic bit was_loaded(input logic [1:0] kind, input int unsigned addr);
        case (kind)
            REQ_LOAD_A: return a_loaded[addr];
            REQ_LOAD_B: return b_loaded[addr];
            default:    return c_loaded[addr];
        endcase
    endfunction

    // Mostly moderate Q16.16 values so that sums do not always saturate
    function automatic logic [31:0] random_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2, 3:    return {{15{r[16]}}, r[16:0]};
            4, 5, 6: return {{12{r[19]}}, r[19:0]};
            7, 8:    return {{8{r[23]}}, r[23:0]};
            default: return r;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Update the stores for a load, or queue every element a run produces
    task automatic absorb_request(input logic [1:0] kind, input logic [2:0] row,
                                  input logic [2:0] col, input logic [31:0] value);
        int unsigned        addr;
        int unsigned        rows;
        int unsigned        cols;
        int unsigned        inner;
        logic [1:0]         md;
        logic signed [31:0] a_val;
        logic signed [71:0] acc;
        element_t           elem;
        addr = row * MAX_DIM_DEF + col;
        if (kind != REQ_RUN)
        begin
            if (row < shape_rows(kind) && col < shape_cols(kind))
            begin
                effective_items++;
                case (kind)
                    REQ_LOAD_A:
                    begin
                        a_words[addr] = value;
                        a_loaded[addr] = 1'b1;
                    end
                    REQ_LOAD_B:
                    begin
                        b_words[addr] = value;
                        b_loaded[addr] = 1'b1;
                    end
                    default:
                    begin
                        c_words[addr] = value;
                        c_loaded[addr] = 1'b1;
                    end
                endcase
            end
        end
        else
        begin
            effective_items++;
            md = active_mode();
            rows = shape_rows(REQ_LOAD_C);
            cols = shape_cols(REQ_LOAD_C);
            inner = shape_rows(REQ_LOAD_B);
            for (int unsigned i = 0; i < rows; i++)
            begin
                for (int unsigned j = 0; j < cols; j++)
                begin
                    // Exact sum in 72 bits, then floor shift by the fraction width
                    acc = '0;
                    for (int unsigned k = 0; k < inner; k++)
                    begin
                        a_val = (md == MODE_PLAIN) ? a_words[i * MAX_DIM_DEF + k]
                                                   : a_words[k * MAX_DIM_DEF + i];
                        acc = acc + a_val * b_words[k * MAX_DIM_DEF + j];
                    end
                    acc = acc >>> 16;
                    if (md == MODE_ACC)
                        acc = acc + c_words[i * MAX_DIM_DEF + j];
                    if (acc > SAT_MAX)
                        elem.value = WORD_MAX;
                    else if (acc < SAT_MIN)
                        elem.value = WORD_MIN;
                    else
                        elem.value = acc[31:0];
                    elem.row = i[2:0];
                    elem.col = j[2:0];
                    elem.last = (i == rows - 1) && (j == cols - 1);
                    pending_elements = {pending_elements, elem};
                end
            end
        end
    endtask

    // Offer one request in bursts with random gaps; valid stays high between back-to-back items
    task automatic send_request(input logic [1:0] kind, input logic [2:0] row,
                                input logic [2:0] col, input logic [31:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {2'b00, value, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_request(kind, row, col, value);
    endtask

    // Hold the sender until every queued element has arrived and the block has settled
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (pending_elements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [3:0] mode_data, input logic [3:0] m_data,
                             input logic [3:0] n_data, input logic [3:0] p_data);
        logic [1:0] reg_index [4];
        logic [3:0] reg_value [4];
        reg_index = '{CFG_MODE, CFG_DIM_M, CFG_DIM_N, CFG_DIM_P};
        reg_value = '{mode_data, m_data, n_data, p_data};
        wait_until_drained();
        for (int w = 0; w < 4; w++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index[w];
            cfg_data <= reg_value[w];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (reg_index[w])
                CFG_MODE:  mode_reg = reg_value[w][1:0];
                CFG_DIM_M: dim_m_reg = reg_value[w];
                CFG_DIM_N: dim_n_reg = reg_value[w];
                default:   dim_p_reg = reg_value[w];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Load any entry the run will read that has never been written, then start the run
    task automatic start_run();
        logic [1:0] kinds [3];
        kinds = '{REQ_LOAD_A, REQ_LOAD_B, REQ_LOAD_C};
        foreach (kinds[q])
        begin
            if (kinds[q] != REQ_LOAD_C || active_mode() == MODE_ACC)
            begin
                for (int unsigned r = 0; r < shape_rows(kinds[q]); r++)
                    for (int unsigned c = 0; c < shape_cols(kinds[q]); c++)
                        if (!was_loaded(kinds[q], r * MAX_DIM_DEF + c))
                            send_request(kinds[q], r[2:0], c[2:0], random_value());
            end
        end
        send_request(REQ_RUN, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom);
    endtask

    // Full 8 x 8 x 8 product with the dimensions and mode left at their reset values
    task automatic test_default_shape();
        for (int r = 0; r < MAX_DIM_DEF; r++)
        begin
            for (int c = 0; c < MAX_DIM_DEF; c++)
            begin
                send_request(REQ_LOAD_A, r[2:0], c[2:0], random_value());
                send_request(REQ_LOAD_B, r[2:0], c[2:0], random_value());
            end
        end
        start_run();
    endtask

    // Sums past 64 bits, both saturation limits and floor rounding of a negative product
    task automatic test_saturation_and_rounding();
        configure({2'b00, MODE_PLAIN}, 4'd1, 4'd2, 4'd1);
        send_request(REQ_LOAD_A, 3'd0, 3'd0, WORD_MIN);
        send_request(REQ_LOAD_A, 3'd0, 3'd1, WORD_MIN);
        send_request(REQ_LOAD_B, 3'd0, 3'd0, WORD_MIN);
        send_request(REQ_LOAD_B, 3'd1, 3'd0, WORD_MIN);
        start_run();
        send_request(REQ_LOAD_B, 3'd0, 3'd0, WORD_MAX);
        send_request(REQ_LOAD_B, 3'd1, 3'd0, WORD_MAX);
        start_run();
        send_request(REQ_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
        send_request(REQ_LOAD_A, 3'd0, 3'd1, 32'h0000_0000);
        send_request(REQ_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
        start_run();
    endtask

    // Transposed product, then the same with a preloaded C pushed past the top
    task automatic test_transposed_modes();
        configure({2'b00, MODE_TRANS}, 4'd2, 4'd1, 4'd1);
        send_request(REQ_LOAD_A, 3'd0, 3'd0, 32'hFFFE_8000);
        send_request(REQ_LOAD_A, 3'd1, 3'd0, 32'h0002_4000);
        send_request(REQ_LOAD_B, 3'd0, 3'd0, 32'h0003_0000);
        send_request(REQ_LOAD_B, 3'd1, 3'd0, 32'hFFFF_C000);
        start_run();
        configure({2'b10, MODE_ACC}, 4'd2, 4'd1, 4'd1);
        send_request(REQ_LOAD_C, 3'd0, 3'd0, 32'h7FFF_FF00);
        send_request(REQ_LOAD_A, 3'd0, 3'd0, 32'h0001_0000);
        send_request(REQ_LOAD_B, 3'd0, 3'd0, 32'h0010_0000);
        start_run();
    endtask

    // Zero and oversized dimensions, with loads outside the clamped shape dropped
    task automatic test_dimension_limits();
        configure({2'b01, MODE_TRANS}, 4'd0, 4'd15, 4'd0);
        send_request(REQ_LOAD_A, 3'd1, 3'd1, WORD_MAX);
        send_request(REQ_LOAD_B, 3'd1, 3'd0, WORD_MIN);
        send_request(REQ_LOAD_B, 3'd0, 3'd1, WORD_MAX);
        send_request(REQ_LOAD_A, 3'd0, 3'd7, WORD_MIN);
        send_request(REQ_LOAD_B, 3'd0, 3'd0, 32'h0001_8000);
        start_run();
    endtask

    // The spare mode code acts as a plain product; it also reads the dropped loads above
    task automatic test_spare_mode();
        configure({2'b11, MODE_UNUSED}, 4'd2, 4'd2, 4'd2);
        start_run();
    endtask

    // Stall the result side long enough to back the block up, then pause the sender
    task automatic test_backpressure();
        configure({2'b00, MODE_PLAIN}, 4'd4, 4'd2, 4'd4);
        hold_off_requests <= hold_off_requests + 1;
        start_run();
        repeat (6)
            send_request($urandom_range(0, 1) ? REQ_LOAD_A : REQ_LOAD_B,
                         3'($urandom_range(0, 1)), 3'($urandom_range(0, 1)), random_value());
        wait_until_drained();
        start_run();
    endtask

    // Random shapes and modes; load sequences with random content, some loads off the shape
    task automatic test_random_traffic();
        int         start_items;
        logic [1:0] kind;
        logic [2:0] row;
        logic [2:0] col;
        start_items = effective_items;
        while (effective_items - start_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       configure(4'($urandom_range(0, 15)), 4'($urandom_range(0, 4)),
                                   4'($urandom_range(0, 4)), 4'($urandom_range(0, 4)));
                default: configure(4'($urandom_range(0, 15)), 4'($urandom_range(1, 4)),
                                   4'($urandom_range(1, 4)), 4'($urandom_range(1, 4)));
            endcase
            repeat ($urandom_range(1, 3))
            begin
                repeat ($urandom_range(0, 10))
                begin
                    kind = 2'($urandom_range(0, 2));
                    if ($urandom_range(0, 4) == 0)
                    begin
                        row = 3'($urandom_range(0, 7));
                        col = 3'($urandom_range(0, 7));
                    end
                    else
                    begin
                        row = 3'($urandom_range(0, shape_rows(kind) - 1));
                        col = 3'($urandom_range(0, shape_cols(kind) - 1));
                    end
                    send_request(kind, row, col, random_value());
                end
                start_run();
            end
        end
    endtask

    // Result side: long hold-off on request, otherwise a rotating random stall pattern
    always @(posedge clk)
    begin
        if (hold_off_seen != hold_off_requests)
        begin
            hold_off_seen = hold_off_requests;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left != 0)
        begin
            hold_off_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (stall_phase == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = 16'($urandom);
                    default: stall_pattern = 16'($urandom | $urandom);
                endcase
            end
            m_tready <= stall_pattern[stall_phase];
            stall_phase = (stall_phase + 1) % 16;
        end
    end

    // Compare each result transfer with the oldest queued element
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_elements.size() == 0)
            begin
                report_mismatch($sformatf("unexpected element row %0d col %0d value %h",
                                          m_tdata[2:0], m_tdata[5:3], m_tdata[37:6]));
            end
            else
            begin
                expected_elem = pending_elements.pop_front();
                if (m_tdata[2:0] !== expected_elem.row)
                    report_mismatch($sformatf("row %0d, expected %0d",
                                              m_tdata[2:0], expected_elem.row));
                if (m_tdata[5:3] !== expected_elem.col)
                    report_mismatch($sformatf("col %0d, expected %0d",
                                              m_tdata[5:3], expected_elem.col));
                if (m_tdata[37:6] !== expected_elem.value)
                    report_mismatch($sformatf("value %h at (%0d,%0d), expected %h",
                                              m_tdata[37:6], expected_elem.row,
                                              expected_elem.col, expected_elem.value));
                if (m_tlast !== expected_elem.last)
                    report_mismatch($sformatf("last %b at (%0d,%0d), expected %b", m_tlast,
                                              expected_elem.row, expected_elem.col,
                                              expected_elem.last));
            end
        end
    end

    // Drop the run if no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d elements outstanding",
                     IDLE_LIMIT, pending_elements.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_shape();
        test_saturation_and_rounding();
        test_transposed_modes();
        test_dimension_limits();
        test_spare_mode();
        test_backpressure();
        test_random_traffic();
        wait_until_drained();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/dmm_pkg.sv
hw/rtl/dmm_mac.sv
hw/rtl/dense_matrix_multiply_top.sv
tb/tb_dense_matrix_multiply_top.sv
